// File: rtl/core/ultrasonic_ranger_scanner_defines.svh
// ----------------------------------------------------------------------------
// ultrasonic ranger scanner assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGER_SCANNER_DEFINES_SVH
`define ULTRASONIC_RANGER_SCANNER_DEFINES_SVH

// property holds at every clock edge out of reset
`define URS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the trigger
`define URS_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// types and constants of the ultrasonic ranger scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urs_pkg;

  localparam int unsigned SensorCountDefault = 4;
  localparam int unsigned EchoLines          = 4;
  localparam int unsigned CfgIdxW            = 4;
  localparam int unsigned CfgDataW           = 16;

  localparam logic [31:0] NoEcho          = 32'hFFFF_FFFF;
  localparam logic [15:0] PulseWidthReset = 16'd600;
  localparam logic [7:0]  SlotMillisReset = 8'd25;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPulseWidth = 4'd0,
    CfgSlotMillis = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic       milli_strobe;
    logic [3:0] echo_falls;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  trigger_lines;
    logic        distance_valid;
    logic [1:0]  distance_channel;
    logic [31:0] distance_value;
    logic        missed_flag;
  } out_item_t;

endpackage

// File: rtl/core/ultrasonic_ranger_scanner.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_scanner
// round-robin trigger and echo timing over a set of ultrasonic sensors
// ----------------------------------------------------------------------------
// usage
//   input channel: one transaction per fine timer tick, carrying the
//   millisecond strobe and the echo falling edges of every sensor
//   output channel: one transaction per tick with the trigger levels, an
//   optional distance (captured tick count or all ones on timeout) and the
//   missed indicator
//   config channel: valid/ready write of pulse_width (index 0) and
//   slot_millis (index 1), always ready; meant only for use while the block is idle, unchecked
// timing
//   an input transaction goes through the input register, then through the
//   slot logic into the result register
//   throughput one tick per cycle unless the output stalls; the loops are the
//   tick counter with its pulse width compare and the millisecond and channel counters
// reset
//   counters clear, the trigger of sensor zero is raised, registers take
//   600 ticks and 25 ms; no result is pending
// stall
//   a stalled result holds; the pipeline advances whenever the result
//   register is empty or being taken, otherwise the input stalls too
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_ranger_scanner #(
  parameter int unsigned SENSOR_COUNT = urs_pkg::SensorCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  urs_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output urs_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [urs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [urs_pkg::CfgDataW-1:0]    cfg_data_i
);

  import urs_pkg::*;

  `include "ultrasonic_ranger_scanner_defines.svh"

  // channel counter just wide enough for the sensor count
  localparam int unsigned ChanW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam logic [ChanW-1:0] LastChan = ChanW'(SENSOR_COUNT - 1);

  // configuration registers
  logic [15:0] pulse_width_q;
  logic [7:0]  slot_millis_q;

  // scanner state
  logic [31:0]      tick_count_q, tick_count_d;
  logic [7:0]       milli_count_q, milli_count_d;
  logic [ChanW-1:0] channel_q, channel_d;
  logic             echo_armed_q, echo_armed_d;
  logic             got_echo_q, got_echo_d;
  logic             trigger_on_q, trigger_on_d;
  logic             missed_led_q, missed_led_d;

  // pipeline registers
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic out_ready;
  logic step;
  logic slot_end;

  // handshake: result register frees when empty or taken this cycle
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_ready;
  assign in_stall_o  = in_valid_q && !out_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_width_q <= PulseWidthReset;
      slot_millis_q <= SlotMillisReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgPulseWidth: pulse_width_q <= cfg_data_i[15:0];
        CfgSlotMillis: slot_millis_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // single pass over one tick
  always_comb begin
    logic [ChanW+2:0] chan_ext;
    logic             has_line;
    logic             fell;
    logic [8:0]       milli_next;
    logic [31:0]      tick_next;

    chan_ext   = (ChanW + 3)'(channel_q);
    // only the first four sensors have echo and trigger wiring
    has_line   = (chan_ext < (ChanW + 3)'(EchoLines));
    fell       = has_line && in_q.echo_falls[chan_ext[1:0]];
    milli_next = {1'b0, milli_count_q} + 9'd1;
    tick_next  = tick_count_q + 32'd1;

    tick_count_d  = tick_count_q;
    milli_count_d = milli_count_q;
    channel_d     = channel_q;
    echo_armed_d  = echo_armed_q;
    got_echo_d    = got_echo_q;
    trigger_on_d  = trigger_on_q;
    missed_led_d  = missed_led_q;
    slot_end      = 1'b0;

    out_d                  = '0;

    // echo capture on the current sensor
    if (echo_armed_q && fell) begin
      echo_armed_d            = 1'b0;
      got_echo_d              = 1'b1;
      out_d.distance_valid    = 1'b1;
      out_d.distance_channel  = chan_ext[1:0];
      out_d.distance_value    = tick_count_q;
    end

    // millisecond slot accounting
    if (in_q.milli_strobe) begin
      if (milli_next >= {1'b0, slot_millis_q}) begin
        slot_end = 1'b1;
      end else begin
        milli_count_d = milli_next[7:0];
      end
    end

    if (slot_end) begin
      milli_count_d = '0;
      echo_armed_d  = 1'b0;
      // a capture in this same tick counts as an echo
      if (!got_echo_d) begin
        missed_led_d           = 1'b1;
        out_d.distance_valid   = 1'b1;
        out_d.distance_channel = chan_ext[1:0];
        out_d.distance_value   = NoEcho;
      end else begin
        missed_led_d = 1'b0;
      end
      got_echo_d   = 1'b0;
      channel_d    = (channel_q == LastChan) ? '0 : channel_q + ChanW'(1);
      trigger_on_d = 1'b1;
      tick_count_d = '0;
    end else begin
      tick_count_d = tick_next;
      // matches again after each 32-bit wrap
      if (tick_next == {16'd0, pulse_width_q}) begin
        trigger_on_d = 1'b0;
        echo_armed_d = 1'b1;
      end
    end

    // trigger level after the tick
    if (trigger_on_d && ((ChanW + 3)'(channel_d) < (ChanW + 3)'(EchoLines))) begin
      out_d.trigger_lines = 4'b0001 << channel_d[((ChanW > 1) ? 1 : 0):0];
    end
    out_d.missed_flag = missed_led_d;
  end

  // state and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q  <= '0;
      milli_count_q <= '0;
      channel_q     <= '0;
      echo_armed_q  <= 1'b0;
      got_echo_q    <= 1'b0;
      trigger_on_q  <= 1'b1;
      missed_led_q  <= 1'b0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (step) begin
        tick_count_q  <= tick_count_d;
        milli_count_q <= milli_count_d;
        channel_q     <= channel_d;
        echo_armed_q  <= echo_armed_d;
        got_echo_q    <= got_echo_d;
        trigger_on_q  <= trigger_on_d;
        missed_led_q  <= missed_led_d;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= step;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  `URS_ASSERT(a_arm_trigger_excl, !(echo_armed_q && trigger_on_q),
              "capture armed while trigger is still high")
  `URS_ASSERT(a_trigger_onehot, !out_valid_q || $onehot0(out_q.trigger_lines),
              "more than one trigger line raised")
  `URS_ASSERT(a_idle_distance_zero,
              !(out_valid_q && !out_q.distance_valid) ||
              (out_q.distance_value == 32'd0 && out_q.distance_channel == 2'd0),
              "distance fields set without distance_valid")
  `URS_ASSERT_NEXT(a_slot_end_clears, step && slot_end,
                   tick_count_q == 32'd0 && milli_count_q == 8'd0 && trigger_on_q,
                   "slot end did not restart the counters and trigger")

endmodule
